FILE: sv/pcsc_pkg.sv
// Shared types, constants and helper functions of the portal column span clipper.
package pcsc_pkg;

    // defaults for top-level parameters
    localparam int MAX_SECTORS_DEF   = 64;
    localparam int SCREEN_HEIGHT_DEF = 512;
    localparam int NUM_RAYS_DEF      = 256;

    // field widths
    localparam int HW   = 16;   // heights, Q12.4
    localparam int SIDW = 7;    // sector id
    localparam int COLW = 8;
    localparam int HDW  = 20;
    localparam int CSW  = 16;
    localparam int DOTW = 10;
    localparam int PSW  = 16;
    localparam int OW   = 14;   // span top / length
    localparam int CW   = 8;    // color channel
    localparam int KW   = 2;

    // arithmetic widths
    localparam int DW   = 21;   // projected distance
    localparam int DVW  = 40;   // dividend / quotient
    localparam int RW   = 42;   // signed screen row, full width
    localparam int DCW  = $clog2(DVW);

    // config port
    localparam int CIW  = 2;
    localparam int CDW  = 16;
    localparam logic [CIW-1:0] CFG_EYE_HEIGHT   = 2'd0;
    localparam logic [CIW-1:0] CFG_START_SECTOR = 2'd1;
    localparam logic [CIW-1:0] CFG_PROJ_SCALE   = 2'd2;

    localparam logic [SIDW-1:0] START_SECTOR_RST = 7'd1;
    localparam logic [PSW-1:0]  PROJ_SCALE_RST   = 16'd256;

    localparam logic [KW-1:0] KIND_SOLID = 2'd0;
    localparam logic [KW-1:0] KIND_UPPER = 2'd1;
    localparam logic [KW-1:0] KIND_LOWER = 2'd2;

    localparam logic [CW-1:0] CMAX = 8'd255;

    typedef struct packed {
        logic                   op;
        logic                   first;
        logic [COLW-1:0]        col;
        logic [HDW-1:0]         hd;
        logic [CSW-1:0]         cs;
        logic [SIDW-1:0]        front;
        logic [SIDW-1:0]        back;
        logic signed [HW-1:0]   ceil_h;
        logic signed [HW-1:0]   floor_h;
        logic signed [DOTW-1:0] dot;
    } t_item;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       ram_we;
        logic       rd_next;
        logic       first_apply;
        logic       lat_cur;
        logic       lat_next;
        logic       mul_ld;
        logic       div_step;
        logic       row_st;
        logic [1:0] k;
        logic       emit_a;
        logic       emit_b;
        logic       update;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic skip;
        logic solid;
        logic out_free;
    } t_stat;

    // saturate a x256 value to one 8-bit channel
    function automatic logic [CW-1:0] sat8(input logic signed [17:0] x);
        logic signed [17:0] s;
        begin
            s = x >>> 8;
            if (x < 0) sat8 = '0;
            else if (s > 18'sd255) sat8 = CMAX;
            else sat8 = s[CW-1:0];
        end
    endfunction

    // shade base: (dot + 256) * 100 + 55 * 256
    function automatic logic signed [17:0] shade(input logic signed [DOTW-1:0] dot);
        logic signed [17:0] d;
        begin
            d = 18'(dot) + 18'sd256;
            shade = d * 18'sd100 + 18'sd14080;
        end
    endfunction

endpackage

FILE: sv/portal_column_span_clipper.sv
// Top level of the portal column span clipper: stream and config ports, sequencer, datapath.
//
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+-------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata hit/load fields, tuser operation
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata span fields, tuser kind, tlast
// cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item at a time. Each height projection runs through the shared 40-step restoring
// divider, two projections for a solid wall and four for a portal.
// Output stalls hold the sequencer in each of its two emit steps while the output
// register is full and not being taken, whether or not that step has a span.
// Reset (synchronous, active low) closes the ray; sector heights are undefined until loaded.
module portal_column_span_clipper #(
    parameter int MAX_SECTORS   = pcsc_pkg::MAX_SECTORS_DEF,
    parameter int SCREEN_HEIGHT = pcsc_pkg::SCREEN_HEIGHT_DEF,
    parameter int NUM_RAYS      = pcsc_pkg::NUM_RAYS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pcsc_pkg::CIW-1:0]  i_cfg_index,
    input  logic [pcsc_pkg::CDW-1:0]  i_cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // first_of_ray[0], ray_index[8:1], hit_distance[28:9], ray_cosine[44:29],
    // front_sector[51:45], back_sector[58:52], ceil_height[74:59],
    // floor_height[90:75], wall_light_dot[100:91], zero[103:101]
    input  logic [103:0]              s_axis_tdata,
    input  logic                      s_axis_tuser,   // operation[0]
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // column[7:0], span_top[21:8], span_length[35:22], red[43:36],
    // green[51:44], blue[59:52], zero[63:60]
    output logic [63:0]               m_axis_tdata,
    output logic [1:0]                m_axis_tuser,   // span_kind[1:0]
    output logic                      m_axis_tlast    // last_span
);
    import pcsc_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_stat stat;

    logic [COLW-1:0] column;
    logic [OW-1:0]   span_top, span_length;
    logic [CW-1:0]   red, green, blue;

    assign item.op      = s_axis_tuser;
    assign item.first   = s_axis_tdata[0];
    assign item.col     = s_axis_tdata[8:1];
    assign item.hd      = s_axis_tdata[28:9];
    assign item.cs      = s_axis_tdata[44:29];
    assign item.front   = s_axis_tdata[51:45];
    assign item.back    = s_axis_tdata[58:52];
    assign item.ceil_h  = s_axis_tdata[74:59];
    assign item.floor_h = s_axis_tdata[90:75];
    assign item.dot     = s_axis_tdata[100:91];

    // config registers always take the write
    assign o_cfg_ready = 1'b1;

    pcsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pcsc_dp #(
        .MAX_SECTORS   (MAX_SECTORS),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .NUM_RAYS      (NUM_RAYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_column      (column),
        .o_span_top    (span_top),
        .o_span_length (span_length),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_span_kind   (m_axis_tuser),
        .o_last_span   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, blue, green, red, span_length, span_top, column};
endmodule

FILE: sv/pcsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcsc_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/pcsc_ctrl.sv
// Sequencer of the portal column span clipper: item flow, projection loop, span emission.
module pcsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pcsc_pkg::t_stat i_stat,
    output pcsc_pkg::t_cmd  o_cmd
);
    import pcsc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_RDCUR = 10'b0000000100,
        S_RDNXT = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_STORE = 10'b0001000000,
        S_EMITA = 10'b0010000000,
        S_EMITB = 10'b0100000000,
        S_UPD   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]     r_k, n_k;
    logic [DCW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.k = r_k;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.is_load) begin
                    o_cmd.ram_we = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.first_apply = 1'b1;
                    n_state = S_RDCUR;
                end
            end
            S_RDCUR: begin
                o_cmd.lat_cur = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state = S_RDNXT;
            end
            S_RDNXT: begin
                o_cmd.lat_next = 1'b1;
                n_k = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_ld = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DCW'(DVW - 1)) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.row_st = 1'b1;
                // solid walls need only the current sector's two rows
                if ((i_stat.solid && r_k == 2'd1) || r_k == 2'd3) begin
                    n_state = S_EMITA;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_EMITA: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_a = 1'b1;
                    n_state = S_EMITB;
                end
            end
            S_EMITB: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_b = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: sv/pcsc_dp.sv
// Datapath of the portal column span clipper: item and ray state, projection, divider, spans.
module pcsc_dp #(
    parameter int MAX_SECTORS   = pcsc_pkg::MAX_SECTORS_DEF,
    parameter int SCREEN_HEIGHT = pcsc_pkg::SCREEN_HEIGHT_DEF,
    parameter int NUM_RAYS      = pcsc_pkg::NUM_RAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcsc_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [pcsc_pkg::CIW-1:0]      i_cfg_index,
    input  logic [pcsc_pkg::CDW-1:0]      i_cfg_data,
    input  pcsc_pkg::t_cmd                i_cmd,
    output pcsc_pkg::t_stat               o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pcsc_pkg::COLW-1:0]     o_column,
    output logic [pcsc_pkg::OW-1:0]       o_span_top,
    output logic [pcsc_pkg::OW-1:0]       o_span_length,
    output logic [pcsc_pkg::CW-1:0]       o_red,
    output logic [pcsc_pkg::CW-1:0]       o_green,
    output logic [pcsc_pkg::CW-1:0]       o_blue,
    output logic [pcsc_pkg::KW-1:0]       o_span_kind,
    output logic                          o_last_span
);
    import pcsc_pkg::*;

    localparam int AW       = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int ROWS     = SCREEN_HEIGHT * 16;
    localparam int WW       = $clog2(ROWS + 1);
    localparam logic signed [RW-1:0] ROWS_FULL = RW'(ROWS);
    localparam logic signed [RW-1:0] ROW_MID   = RW'(SCREEN_HEIGHT * 8);

    // configuration
    logic signed [HW-1:0] r_eye;
    logic [SIDW-1:0]      r_start;
    logic [PSW-1:0]       r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye   <= '0;
            r_start <= START_SECTOR_RST;
            r_scale <= PROJ_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EYE_HEIGHT:   r_eye   <= i_cfg_data;
                CFG_START_SECTOR: r_start <= i_cfg_data[SIDW-1:0];
                CFG_PROJ_SCALE:   r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    t_item r_it;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_it <= i_item;
    end

    // ray state
    logic [SIDW-1:0] r_cur, r_next;
    logic [WW-1:0]   r_wt, r_wb;
    logic            r_closed;

    function automatic logic id_ok(input logic [SIDW-1:0] id);
        id_ok = (id != '0) && (32'(id) <= MAX_SECTORS);
    endfunction

    function automatic logic [WW-1:0] clamp_rows(input logic signed [RW-1:0] v);
        if (v < 0) clamp_rows = '0;
        else if (v > ROWS_FULL) clamp_rows = WW'(ROWS);
        else clamp_rows = v[WW-1:0];
    endfunction

    logic [SIDW-1:0] cur_eff;
    assign cur_eff = r_it.first ? r_start : r_cur;

    assign o_stat.is_load = !r_it.op;
    assign o_stat.skip    = !(32'(r_it.col) < NUM_RAYS) || (!r_it.first && r_closed);
    assign o_stat.solid   = (r_it.back == '0);

    // sector height table
    logic [SIDW-1:0]   rd_id;
    logic [2*HW-1:0]   ram_rdata;
    logic              r_rd_ok;

    function automatic logic [SIDW-1:0] r_next_c();
        r_next_c = (r_cur == r_it.front) ? r_it.back : r_it.front;
    endfunction

    assign rd_id = i_cmd.rd_next ? r_next_c() : cur_eff;

    pcsc_ram #(.W(2 * HW), .D(MAX_SECTORS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we && id_ok(r_it.front)),
        .i_waddr (AW'(r_it.front - 1'b1)),
        .i_wdata ({r_it.ceil_h, r_it.floor_h}),
        .i_raddr (AW'(rd_id - 1'b1)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) r_rd_ok <= id_ok(rd_id);

    logic signed [HW-1:0] r_cc, r_cf, r_nc, r_nf;
    logic signed [HW-1:0] rd_c, rd_f;
    assign rd_c = r_rd_ok ? ram_rdata[2*HW-1:HW] : '0;
    assign rd_f = r_rd_ok ? ram_rdata[HW-1:0]    : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_cur) begin
            r_cc   <= rd_c;
            r_cf   <= rd_f;
            r_next <= r_next_c();
        end
        if (i_cmd.lat_next) begin
            r_nc <= rd_c;
            r_nf <= rd_f;
        end
    end

    // projected distance, saturated to one LSB
    logic [DW-1:0]        r_dist;
    logic [HDW+CSW-1:0]   dprod;
    assign dprod = r_it.hd * r_it.cs;
    always_ff @(posedge i_clk) begin
        if (i_cmd.first_apply) r_dist <= (dprod[HDW+CSW-1:15] == '0) ? DW'(1) : dprod[HDW+CSW-1:15];
    end

    // height relative to the eye, magnitude times scale
    logic signed [HW-1:0] h_sel;
    logic signed [HW:0]   diff;
    logic [HW-1:0]        mag;
    always_comb begin
        case (i_cmd.k)
            2'd0:    h_sel = r_cc;
            2'd1:    h_sel = r_cf;
            2'd2:    h_sel = r_nc;
            default: h_sel = r_nf;
        endcase
        diff = (HW+1)'(h_sel) - (HW+1)'(r_eye);
        mag  = diff[HW] ? HW'(-diff) : diff[HW-1:0];
    end

    // restoring divider, one quotient bit per cycle
    logic [DVW-1:0] r_dvd;
    logic [DW-1:0]  r_rem;
    logic           r_neg;
    logic [DW:0]    trial;
    logic           tge;
    assign trial = {r_rem, r_dvd[DVW-1]};
    assign tge   = (trial >= (DW+1)'(r_dist));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ld) begin
            r_dvd <= {(HW+PSW)'(mag) * (HW+PSW)'(r_scale), 8'd0};
            r_rem <= '0;
            r_neg <= diff[HW];
        end else if (i_cmd.div_step) begin
            r_rem <= tge ? DW'(trial - (DW+1)'(r_dist)) : trial[DW-1:0];
            r_dvd <= {r_dvd[DVW-2:0], tge};
        end
    end

    logic signed [RW-1:0] qs;
    assign qs = r_neg ? -$signed(RW'(r_dvd)) : $signed(RW'(r_dvd));

    // rows: 0 cur ceiling, 1 cur floor, 2 next ceiling, 3 next floor
    logic signed [RW-1:0] r_row [4];
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_st) r_row[i_cmd.k] <= ROW_MID - qs;
    end

    // span candidates against the window
    logic signed [RW-1:0] wt, wb, a_top, a_bot, b_top, b_bot;
    logic signed [RW-1:0] up_row, new_t, new_b;
    logic                 a_ok, b_ok;
    logic [WW-1:0]        nwt, nwb;
    always_comb begin
        wt     = $signed(RW'(r_wt));
        wb     = $signed(RW'(r_wb));
        up_row = o_stat.solid ? r_row[1] : r_row[2];
        a_top  = (wt > r_row[0]) ? wt : r_row[0];
        a_bot  = (wb < up_row) ? wb : up_row;
        a_ok   = (a_bot > a_top) && (o_stat.solid || (r_row[2] > r_row[0]));
        b_top  = (wt > r_row[3]) ? wt : r_row[3];
        b_bot  = (wb < r_row[1]) ? wb : r_row[1];
        b_ok   = !o_stat.solid && (r_row[3] < r_row[1]) && (b_bot > b_top);
        new_t  = (r_row[0] > r_row[2]) ? r_row[0] : r_row[2];
        new_t  = (wt > new_t) ? wt : new_t;
        new_b  = (r_row[1] < r_row[3]) ? r_row[1] : r_row[3];
        new_b  = (wb < new_b) ? wb : new_b;
        nwt    = clamp_rows(new_t);
        nwb    = clamp_rows(new_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= START_SECTOR_RST;
            r_wt     <= '0;
            r_wb     <= WW'(ROWS);
            r_closed <= 1'b1;
        end else if (i_cmd.first_apply && r_it.first) begin
            r_cur    <= r_start;
            r_wt     <= '0;
            r_wb     <= WW'(ROWS);
            r_closed <= 1'b0;
        end else if (i_cmd.update) begin
            if (o_stat.solid) begin
                r_closed <= 1'b1;
            end else begin
                r_wt <= nwt;
                r_wb <= nwb;
                if (nwt >= nwb) r_closed <= 1'b1;
                else r_cur <= r_next;
            end
        end
    end

    // output register
    logic signed [17:0] x;
    logic               r_ovalid;
    logic               ld_a, ld_b;
    assign x    = shade(r_it.dot);
    assign ld_a = i_cmd.emit_a && a_ok;
    assign ld_b = i_cmd.emit_b && b_ok;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (ld_a || ld_b) r_ovalid <= 1'b1;
        else if (i_out_ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            o_column      <= r_it.col;
            o_span_top    <= a_top[OW-1:0];
            o_span_length <= OW'(a_bot - a_top);
            o_last_span   <= !b_ok;
            if (o_stat.solid) begin
                o_red       <= sat8(x);
                o_green     <= sat8(x - 18'sd1280);
                o_blue      <= sat8(x - 18'sd8960);
                o_span_kind <= KIND_SOLID;
            end else begin
                o_red       <= CMAX;
                o_green     <= '0;
                o_blue      <= '0;
                o_span_kind <= KIND_UPPER;
            end
        end else if (ld_b) begin
            o_column      <= r_it.col;
            o_span_top    <= b_top[OW-1:0];
            o_span_length <= OW'(b_bot - b_top);
            o_last_span   <= 1'b1;
            o_red         <= '0;
            o_green       <= CMAX;
            o_blue        <= '0;
            o_span_kind   <= KIND_LOWER;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
